// ===== rtl/nket_pkg.sv =====
// ----------------------------------------------------------------------------
// nket_pkg
// Types, codes and text helpers shared by the keyed entry table.
// ----------------------------------------------------------------------------
package nket_pkg;

  // Text layout: four words (64/64/64/40 bits), character 0 in the MSB
  localparam int TEXT_W     = 232;
  localparam int MAX_CHARS  = 29;
  localparam int CHAR_LIMIT = 29;

  typedef logic [TEXT_W-1:0] text_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_DUMP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [39:0] key_word3;
    logic [63:0] value_word0;
    logic [63:0] value_word1;
    logic [63:0] value_word2;
    logic [39:0] value_word3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] out_key_word0;
    logic [63:0] out_key_word1;
    logic [63:0] out_key_word2;
    logic [39:0] out_key_word3;
    logic [63:0] out_value_word0;
    logic [63:0] out_value_word1;
    logic [63:0] out_value_word2;
    logic [39:0] out_value_word3;
    logic [6:0]  occupied_count;
    logic        last_result;
  } out_item_t;

  // Clear every character from the first NUL (or past the length limit) on
  function automatic text_t norm_text(text_t t);
    text_t r;
    logic  ended;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (i >= CHAR_LIMIT || t[TEXT_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[TEXT_W-1-8*i -: 8] = t[TEXT_W-1-8*i -: 8];
    end
    return r;
  endfunction

endpackage

// ===== rtl/nket_ram.sv =====
// ----------------------------------------------------------------------------
// nket_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nket_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/name_keyed_entry_table_top.sv =====
// ----------------------------------------------------------------------------
// name_keyed_entry_table_top
// Compact keyed table with insert, delete, search and dump requests.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. Insert
// completes in the accepting cycle and its result strobes on out_valid in
// the next cycle. Search and delete walk the occupied entries one per cycle
// through the read port of the entry RAMs; a delete that hits then moves
// each later entry down one slot per cycle. Dump emits one entry per cycle,
// last_result marking the final one. Every transaction yields at least one
// result. Results are strobed for one cycle only; the receiver cannot hold
// them off. No clearing pass is needed after reset: only occupied entries
// are read.
module name_keyed_entry_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  nket_pkg::in_item_t  in_item,
  output logic                out_valid,
  output nket_pkg::out_item_t out_item
);
  import nket_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = CW + 1;

  state_t       state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [1:0]    req_r, req_nxt;
  text_t         key_r, key_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  text_t         key_wdata, val_wdata, key_rdata, val_rdata;

  logic          accept;
  logic [IW-1:0] idx_p1, idx_p2, cnt_w;
  text_t         in_key_n, in_val_n, emit_key, emit_val;
  logic          emit, emit_last, hit;
  logic [1:0]    emit_status;

  // Entry storage
  nket_ram #(.WIDTH(TEXT_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(key_wdata),
    .rd_addr(rd_addr), .rd_data(key_rdata)
  );

  nket_ram #(.WIDTH(TEXT_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(val_wdata),
    .rd_addr(rd_addr), .rd_data(val_rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign in_key_n = norm_text({in_item.key_word0, in_item.key_word1,
                               in_item.key_word2, in_item.key_word3});
  assign in_val_n = norm_text({in_item.value_word0, in_item.value_word1,
                               in_item.value_word2, in_item.value_word3});

  assign idx_p1 = IW'(idx_r) + IW'(1);
  assign idx_p2 = IW'(idx_r) + IW'(2);
  assign cnt_w  = IW'(cnt_r);
  assign hit    = (key_rdata == key_r);

  // Sequencer: next state, RAM controls and result
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    req_nxt     = req_r;
    key_nxt     = key_r;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    key_wdata   = key_rdata;
    val_wdata   = val_rdata;
    rd_addr     = '0;
    emit        = 1'b0;
    emit_last   = 1'b1;
    emit_status = STAT_OK;
    emit_key    = '0;
    emit_val    = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_item.req_type;
          key_nxt = in_key_n;
          idx_nxt = '0;
          case (in_item.req_type)
            REQ_INSERT: begin
              emit = 1'b1;
              if (cnt_r == CW'(TABLE_DEPTH)) begin
                emit_status = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = AW'(cnt_r);
                key_wdata = in_key_n;
                val_wdata = in_val_n;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            REQ_DUMP: begin
              if (cnt_r == '0) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                state_nxt = ST_DUMP;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
          endcase
        end
      end

      // Compare entry idx_r while entry idx_r + 1 is read
      ST_SCAN: begin
        rd_addr = AW'(idx_p1);
        if (hit) begin
          if (req_r == REQ_SEARCH) begin
            emit      = 1'b1;
            emit_key  = key_rdata;
            emit_val  = val_rdata;
            state_nxt = ST_IDLE;
          end else if (idx_p1 == cnt_w) begin
            emit      = 1'b1;
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SHIFT;
          end
        end else if (idx_p1 == cnt_w) begin
          emit        = 1'b1;
          emit_status = STAT_NOT_FOUND;
          state_nxt   = ST_IDLE;
        end else begin
          idx_nxt = AW'(idx_p1);
        end
      end

      // Entry idx_r + 1 is on the read port; move it down to idx_r
      ST_SHIFT: begin
        rd_addr = AW'(idx_p2);
        wr_en   = 1'b1;
        wr_addr = idx_r;
        if (idx_p2 == cnt_w) begin
          emit      = 1'b1;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = AW'(idx_p1);
        end
      end

      ST_DUMP: begin
        rd_addr   = AW'(idx_p1);
        emit      = 1'b1;
        emit_key  = key_rdata;
        emit_val  = val_rdata;
        emit_last = (idx_p1 == cnt_w);
        if (emit_last) state_nxt = ST_IDLE;
        else idx_nxt = AW'(idx_p1);
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Result register contents
    out_valid_nxt               = emit;
    out_nxt.status              = emit_status;
    out_nxt.out_key_word0       = emit_key[231:168];
    out_nxt.out_key_word1       = emit_key[167:104];
    out_nxt.out_key_word2       = emit_key[103:40];
    out_nxt.out_key_word3       = emit_key[39:0];
    out_nxt.out_value_word0     = emit_val[231:168];
    out_nxt.out_value_word1     = emit_val[167:104];
    out_nxt.out_value_word2     = emit_val[103:40];
    out_nxt.out_value_word3     = emit_val[39:0];
    out_nxt.occupied_count      = 7'(cnt_nxt);
    out_nxt.last_result         = emit_last;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    req_r <= req_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last_result |-> !busy)
    else $error("final result while sequencer still busy");

  a_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last_result |-> state_r == ST_DUMP)
    else $error("non-final result outside a dump");

  a_shift_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |-> cnt_r >= CW'(2))
    else $error("shift with fewer than two entries");

endmodule

// ===== tb/name_keyed_entry_table_top_test.sv =====
// ----------------------------------------------------------------------------
// name_keyed_entry_table_top_test
// Self-checking bench for the keyed entry table.
// ----------------------------------------------------------------------------
// Requests are driven through the start/busy handshake. Each accepted
// transaction is run through a behavioral copy of the table, which queues the
// results it should produce. Every strobed result is then compared field by
// field with the oldest queued one. Directed tests cover the empty table,
// text termination edge cases, delete shifting, duplicate keys and a full
// table. Random traffic follows, with the sender idling at several rates.
// ----------------------------------------------------------------------------
module name_keyed_entry_table_top_test;
  import nket_pkg::*;

  localparam int DEPTH        = 64;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 140;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Behavioral table state, updated at each accepted transaction
  text_t     table_keys [DEPTH];
  text_t     table_vals [DEPTH];
  int        table_count;
  out_item_t table_results_due [$];

  int fail_count    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;

  name_keyed_entry_table_top #(.TABLE_DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Clock: period 12
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[name_keyed_entry_table_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Text helpers
  // ---------------------------------------------------------------------------

  // Characters up to the first NUL, capped at the length limit
  function automatic int text_len(text_t t);
    for (int i = 0; i < CHAR_LIMIT; i++)
      if (t[TEXT_W-1-8*i -: 8] == 8'h00) return i;
    return CHAR_LIMIT;
  endfunction

  // Keep only the leading characters; everything after them reads as zero
  function automatic text_t clean_text(text_t raw);
    text_t ones;
    ones = '1;
    return raw & ~(ones >> (8 * text_len(raw)));
  endfunction

  // Random text of len characters, random junk after the terminator
  function automatic text_t rand_text(int len);
    text_t t;
    t = '0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (i < len) t[TEXT_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
      else if (i > len && $urandom_range(1) == 1)
        t[TEXT_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
    end
    return t;
  endfunction

  // Length mix: short, full-length and anything between
  function automatic int rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 15) return $urandom_range(0, 2);
    if (r < 35) return CHAR_LIMIT;
    return $urandom_range(0, CHAR_LIMIT);
  endfunction

  // Same key after termination, different raw bits
  function automatic text_t add_junk(text_t k);
    text_t t;
    int    len;
    t   = k;
    len = text_len(k);
    for (int i = len + 1; i < MAX_CHARS; i++)
      if ($urandom_range(1) == 1) t[TEXT_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
    return t;
  endfunction

  function automatic in_item_t make_item(req_e req, text_t k, text_t v);
    in_item_t it;
    it.req_type = req;
    {it.key_word0, it.key_word1, it.key_word2, it.key_word3} = k;
    {it.value_word0, it.value_word1, it.value_word2, it.value_word3} = v;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void queue_result(status_e st, text_t k, text_t v, bit last);
    out_item_t r;
    r.status = st;
    {r.out_key_word0, r.out_key_word1, r.out_key_word2, r.out_key_word3} = k;
    {r.out_value_word0, r.out_value_word1, r.out_value_word2, r.out_value_word3} = v;
    r.occupied_count = table_count[6:0];
    r.last_result    = last;
    table_results_due.push_back(r);
  endfunction

  function automatic void predict_table_results(in_item_t it);
    text_t k;
    text_t v;
    int    hit;
    k   = clean_text({it.key_word0, it.key_word1, it.key_word2, it.key_word3});
    v   = clean_text({it.value_word0, it.value_word1, it.value_word2, it.value_word3});
    hit = -1;
    case (req_e'(it.req_type))
      REQ_INSERT: begin
        if (table_count >= DEPTH) begin
          queue_result(STAT_FULL, '0, '0, 1'b1);
        end else begin
          table_keys[table_count] = k;
          table_vals[table_count] = v;
          table_count++;
          queue_result(STAT_OK, '0, '0, 1'b1);
        end
      end
      REQ_DUMP: begin
        if (table_count == 0) queue_result(STAT_EMPTY, '0, '0, 1'b1);
        for (int e = 0; e < table_count; e++)
          queue_result(STAT_OK, table_keys[e], table_vals[e], e == table_count - 1);
      end
      default: begin
        // search and delete share the lookup of the first match
        for (int e = 0; e < table_count; e++)
          if (hit < 0 && table_keys[e] == k) hit = e;
        if (table_count == 0) begin
          queue_result(STAT_EMPTY, '0, '0, 1'b1);
        end else if (hit < 0) begin
          queue_result(STAT_NOT_FOUND, '0, '0, 1'b1);
        end else if (it.req_type == REQ_SEARCH) begin
          queue_result(STAT_OK, table_keys[hit], table_vals[hit], 1'b1);
        end else begin
          for (int e = hit; e < table_count - 1; e++) begin
            table_keys[e] = table_keys[e+1];
            table_vals[e] = table_vals[e+1];
          end
          table_count--;
          queue_result(STAT_OK, '0, '0, 1'b1);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at cycle %0d:%s", cycle_count, msg);
  endtask

  function automatic string field_diff(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) return $sformatf(" %s exp %h got %h", name, e, a);
    return "";
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    string     diff;
    if (table_results_due.size() == 0) begin
      note_failure($sformatf(" unexpected result, status %0d count %0d",
                             got.status, got.occupied_count));
      return;
    end
    want = table_results_due.pop_front();
    diff = {field_diff("status", 64'(want.status), 64'(got.status)),
            field_diff("key0", want.out_key_word0, got.out_key_word0),
            field_diff("key1", want.out_key_word1, got.out_key_word1),
            field_diff("key2", want.out_key_word2, got.out_key_word2),
            field_diff("key3", 64'(want.out_key_word3), 64'(got.out_key_word3)),
            field_diff("value0", want.out_value_word0, got.out_value_word0),
            field_diff("value1", want.out_value_word1, got.out_value_word1),
            field_diff("value2", want.out_value_word2, got.out_value_word2),
            field_diff("value3", 64'(want.out_value_word3), 64'(got.out_value_word3)),
            field_diff("count", 64'(want.occupied_count), 64'(got.occupied_count)),
            field_diff("last", 64'(want.last_result), 64'(got.last_result))};
    if (diff != "") note_failure(diff);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) check_result(out_item);
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_item = it;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    predict_table_results(it);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send(req_e req, text_t k, text_t v);
    send_request(make_item(req, k, v));
  endtask

  // Key of a random occupied entry, with fresh junk past its end
  function automatic text_t stored_key();
    return add_junk(table_keys[$urandom_range(0, table_count - 1)]);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  text_t ones;
  text_t junk_only;
  text_t key_short;

  // Dump, search and delete on an empty table each report empty
  task automatic test_empty_table();
    send(REQ_DUMP, '0, ones);
    send(REQ_SEARCH, junk_only, '0);
    send(REQ_DELETE, '0, junk_only);
  endtask

  // Empty key, full-length key and value, junk after the terminator
  task automatic test_text_edges();
    text_t k;
    send(REQ_INSERT, '0, ones);
    send(REQ_INSERT, ones, junk_only);
    send(REQ_INSERT, key_short, rand_text(CHAR_LIMIT));
    send(REQ_SEARCH, junk_only, '0);
    send(REQ_SEARCH, add_junk(key_short), ones);
    // one character short of the stored full-length key
    k = ones;
    k[TEXT_W-1-8*(CHAR_LIMIT-1) -: 8] = 8'h00;
    send(REQ_SEARCH, k, '0);
    k = '0;
    k[TEXT_W-1 -: 16] = 16'h6100;
    send(REQ_DELETE, add_junk(k), ones);
    send(REQ_DUMP, junk_only, '0);
  endtask

  // Delete from the middle and front, duplicate keys, delete down to empty
  task automatic test_delete_shift();
    send(REQ_DELETE, ones, '0);
    send(REQ_DUMP, '0, '0);
    send(REQ_INSERT, add_junk(key_short), rand_text(rand_len()));
    send(REQ_SEARCH, key_short, '0);
    send(REQ_DELETE, junk_only, '0);
    send(REQ_DUMP, '0, '0);
    repeat (3) send(REQ_DELETE, add_junk(key_short), '0);
    send(REQ_DUMP, '0, '0);
  endtask

  // Fill the table, overflow it, dump all entries, delete at both ends
  task automatic test_full_table();
    text_t last_key;
    while (table_count < DEPTH) send(REQ_INSERT, rand_text(rand_len()), rand_text(rand_len()));
    send(REQ_INSERT, ones, ones);
    send(REQ_DUMP, '0, '0);
    last_key = table_keys[DEPTH-1];
    send(REQ_SEARCH, add_junk(last_key), '0);
    send(REQ_DELETE, add_junk(table_keys[DEPTH-1]), '0);
    send(REQ_DELETE, add_junk(table_keys[0]), '0);
    send(REQ_INSERT, rand_text(rand_len()), rand_text(rand_len()));
    send(REQ_INSERT, rand_text(rand_len()), rand_text(rand_len()));
    send(REQ_INSERT, '0, '0);
    send(REQ_SEARCH, add_junk(table_keys[DEPTH-1]), '0);
  endtask

  // Mixed traffic; the insert share follows the fill level so that the
  // table swings between nearly empty and full
  task automatic test_random_traffic(int idle_pct, int n);
    int    ins_pct;
    int    r;
    text_t k;
    send_idle_pct = idle_pct;
    repeat (n) begin
      if (table_count > 48) ins_pct = 15;
      else if (table_count < 8) ins_pct = 60;
      else ins_pct = 40;
      if (table_count > 0 && $urandom_range(99) < 75) k = stored_key();
      else k = rand_text(rand_len());
      if ($urandom_range(99) < ins_pct) begin
        send(REQ_INSERT, k, rand_text(rand_len()));
      end else begin
        r = $urandom_range(99);
        if (r < 45) send(REQ_SEARCH, k, rand_text(rand_len()));
        else if (r < 88) send(REQ_DELETE, k, rand_text(rand_len()));
        else send(REQ_DUMP, k, rand_text(rand_len()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    table_count = 0;
    ones        = '1;
    junk_only   = ones >> 8;
    key_short   = '0;
    key_short[TEXT_W-1 -: 40] = 40'h61_62_00_C3_5A;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 19;
    test_empty_table();
    test_text_edges();
    test_delete_shift();
    test_full_table();
    test_random_traffic(19, 80);
    test_random_traffic(46, 80);
    test_random_traffic(0, 80);

    while (table_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && table_results_due.size() == 0) begin
      $display("[name_keyed_entry_table_top] OK");
    end else begin
      $display("[name_keyed_entry_table_top] ERROR");
    end
    $finish;
  end

endmodule
